// File: hw/rtl/spbg_pkg.sv
// ----------------------------------------------------------------------------
// spbg_pkg
// Shared widths, register and step codes, and the structs that pass between
// the scan point grouper modules.
// ----------------------------------------------------------------------------
package spbg_pkg;

	localparam int XY_W   = 24;
	localparam int IDX_W  = 10;
	localparam int CNT_W  = 11;
	localparam int ROOT_W = 29;
	localparam int SQ_W   = 2 * ROOT_W;
	localparam int LIMB_W = 32;
	localparam int LIMBS  = 5;
	localparam int BIG_W  = LIMBS * LIMB_W;
	localparam int APB_AW = 5;

	localparam logic [CNT_W-1:0] CNT_MAX = 11'd2047;

	// register indexes (byte address / 4)
	localparam logic [2:0] REG_BASE_GAP     = 3'd0;
	localparam logic [2:0] REG_GAP_PROP     = 3'd1;
	localparam logic [2:0] REG_SINE_THR     = 3'd2;
	localparam logic [2:0] REG_MIN_SIZE     = 3'd3;
	localparam logic [2:0] REG_DOUBLE_FIRST = 3'd4;

	// multiply steps of the Heron comparison
	localparam logic [2:0] MS_F2 = 3'd0;
	localparam logic [2:0] MS_F3 = 3'd1;
	localparam logic [2:0] MS_F4 = 3'd2;
	localparam logic [2:0] MS_A  = 3'd3;
	localparam logic [2:0] MS_B1 = 3'd4;
	localparam logic [2:0] MS_B2 = 3'd5;
	localparam logic [2:0] MS_T1 = 3'd6;
	localparam logic [2:0] MS_T2 = 3'd7;

	typedef struct packed {
		logic signed [XY_W-1:0] point_x_mm;
		logic signed [XY_W-1:0] point_y_mm;
		logic                   final_point;
	} point_t;

	typedef struct packed {
		logic [IDX_W-1:0] group_first;
		logic [IDX_W-1:0] group_last;
		logic [CNT_W-1:0] point_count;
		logic             front_seen;
		logic             back_seen;
		logic             occlusion_break;
		logic             too_small;
		logic             last_of_sweep;
	} group_t;

	typedef struct packed {
		logic [15:0]      base_gap_mm;
		logic [15:0]      gap_proportion_q16;
		logic [16:0]      sine_threshold_q16;
		logic [CNT_W-1:0] min_group_size;
		logic             double_first_point;
	} cfg_t;

	typedef struct packed {
		logic       load;
		logic       sq_mul;
		logic       root_start;
		logic       gap_mul;
		logic       join_grp;
		logic       h_load;
		logic       mul_en;
		logic [2:0] mul_step;
		logic       mul_last;
		logic       swap;
		logic       cmp;
		logic       emit_brk;
		logic       post;
		logic       emit_fin;
	} cmd_t;

	typedef struct packed {
		logic process;
		logic join_ok;
		logic fin;
		logic roots_done;
		logic out_free;
	} sts_t;

endpackage

// File: hw/rtl/spbg_stream_if.sv
// ----------------------------------------------------------------------------
// spbg_stream_if
// Valid/ready channel that carries one word of type T.
// ----------------------------------------------------------------------------
interface spbg_stream_if #(parameter type T = logic);
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// File: hw/rtl/spbg_isqrt.sv
// ----------------------------------------------------------------------------
// spbg_isqrt
// Integer square root, one result bit per cycle (floor of the root).
// ----------------------------------------------------------------------------
module spbg_isqrt (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [spbg_pkg::SQ_W-1:0]     value,
	output logic                          done,
	output logic [spbg_pkg::ROOT_W-1:0]   root
);
	localparam int RootW = spbg_pkg::ROOT_W;
	localparam int SqW   = spbg_pkg::SQ_W;
	localparam int RemW  = RootW + 1;
	localparam int TryW  = RootW + 3;
	localparam int CW    = $clog2(RootW);
	localparam logic [CW-1:0] StepLast = CW'(RootW - 1);

	logic            busy_q;
	logic            done_q;
	logic [CW-1:0]   cnt_q;
	logic [SqW-1:0]  val_q;
	logic [RemW-1:0] rem_q;
	logic [RootW-1:0] root_q;
	logic [TryW-1:0] rem_n;
	logic [TryW-1:0] trial;
	logic            ge;

	// bring down two bits, try the next root bit
	assign rem_n = {rem_q, val_q[SqW-1 -: 2]};
	assign trial = {1'b0, root_q, 2'b01};
	assign ge    = rem_n >= trial;

	// sequence the iterations
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				if (cnt_q == StepLast) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q + 1'b1;
				end
			end
		end
	end

	// remainder and root
	always_ff @(posedge clk) begin
		if (start) begin
			val_q  <= value;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			val_q  <= {val_q[SqW-3:0], 2'b00};
			rem_q  <= ge ? RemW'(rem_n - trial) : RemW'(rem_n);
			root_q <= {root_q[RootW-2:0], ge};
		end
	end

	assign done = done_q;
	assign root = root_q;
endmodule

// File: hw/rtl/spbg_dpath.sv
// ----------------------------------------------------------------------------
// spbg_dpath
// Grouper datapath: squares, roots, gap test, Heron comparison through a
// limb-serial multiplier, open group state and the result register.
// ----------------------------------------------------------------------------
module spbg_dpath #(
	parameter int MAX_POINTS = 1024
) (
	input  logic                clk,
	input  logic                arst_n,
	input  spbg_pkg::cfg_t      cfg,
	input  spbg_pkg::cmd_t      cmd,
	output spbg_pkg::sts_t      sts,
	input  spbg_pkg::point_t    pt,
	input  logic                out_ready,
	output logic                out_valid,
	output spbg_pkg::group_t    out_grp
);
	localparam int IW    = $clog2(MAX_POINTS);
	localparam int IdxW  = spbg_pkg::IDX_W;
	localparam int CntW  = spbg_pkg::CNT_W;
	localparam int RootW = spbg_pkg::ROOT_W;
	localparam int LimbW = spbg_pkg::LIMB_W;
	localparam int BigW  = spbg_pkg::BIG_W;
	localparam int LhsW  = BigW - LimbW;
	localparam logic [IW-1:0] IdxLast = IW'(MAX_POINTS - 1);

	// point and group state
	logic signed [23:0] x_q, y_q, prev_x_q, prev_y_q;
	logic               fin_q, self_q, process_q, started_q;
	logic [IW-1:0]      cnt_q, idx_q, open_first_q;
	logic [CntW-1:0]    count_q;
	logic               fv_q;

	// squares and roots
	logic signed [24:0] dx, dy;
	logic signed [47:0] xx_full, yy_full;
	logic signed [49:0] dxx_full, dyy_full;
	logic [46:0]        xx_q, yy_q;
	logic [48:0]        dxx_q, dyy_q;
	logic [47:0]        r2_sum, r2_q, prev_r2_q, p2_q;
	logic [49:0]        d2_sum;
	logic [RootW-1:0]   rq, dq, prev_rq_q, b_q;
	logic               r_done, d_done;
	logic [44:0]        prod_q;
	logic [29:0]        thr;

	// Heron comparison
	logic [30:0]        abc;
	logic signed [30:0] f2, f3, f4;
	logic [29:0]        f2m_q, f3m_q, f4m_q;
	logic               undef_q, nearer_q, occl_q, gt_q;
	logic [BigW-1:0]    big_q, lhs_wide;
	logic [LhsW-1:0]    lhs_q;
	logic [LimbW-1:0]   carry_q, fac;
	logic [2*LimbW-1:0] mac;
	logic [IW-1:0]      prev_idx;
	logic               out_valid_q;
	spbg_pkg::group_t   out_q;

	// differences and squares
	assign dx       = {x_q[23], x_q} - {prev_x_q[23], prev_x_q};
	assign dy       = {y_q[23], y_q} - {prev_y_q[23], prev_y_q};
	assign xx_full  = x_q * x_q;
	assign yy_full  = y_q * y_q;
	assign dxx_full = dx * dx;
	assign dyy_full = dy * dy;
	assign r2_sum   = {1'b0, xx_q} + {1'b0, yy_q};
	assign d2_sum   = {1'b0, dxx_q} + {1'b0, dyy_q};

	spbg_isqrt u_root_r (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.root_start),
		.value  ({2'b00, r2_sum, 8'h00}),
		.done   (r_done),
		.root   (rq)
	);

	spbg_isqrt u_root_d (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.root_start),
		.value  ({d2_sum, 8'h00}),
		.done   (d_done),
		.root   (dq)
	);

	// adaptive gap threshold in Q.4 mm
	assign thr = 30'({cfg.base_gap_mm, 4'h0}) + 30'(prod_q[44:16]);

	// Heron factors from the two ranges and the distance
	assign abc = 31'(rq) + 31'(b_q) + 31'(dq);
	assign f2  = $signed({2'b00, b_q}) + $signed({2'b00, dq}) - $signed({2'b00, rq});
	assign f3  = $signed({2'b00, rq}) + $signed({2'b00, dq}) - $signed({2'b00, b_q});
	assign f4  = $signed({2'b00, rq}) + $signed({2'b00, b_q}) - $signed({2'b00, dq});

	// factor of the current multiply step
	always_comb begin
		case (cmd.mul_step) inside
			spbg_pkg::MS_F2: fac = LimbW'(f2m_q);
			spbg_pkg::MS_F3: fac = LimbW'(f3m_q);
			spbg_pkg::MS_F4: fac = LimbW'(f4m_q);
			spbg_pkg::MS_A:  fac = LimbW'(rq);
			spbg_pkg::MS_B1, spbg_pkg::MS_B2: fac = LimbW'(b_q);
			spbg_pkg::MS_T1, spbg_pkg::MS_T2: fac = LimbW'(cfg.sine_threshold_q16);
			default: fac = '0;
		endcase
	end

	assign mac      = (2*LimbW)'(big_q[LimbW-1:0]) * (2*LimbW)'(fac)
		+ (2*LimbW)'(carry_q);
	assign lhs_wide = {lhs_q, {LimbW{1'b0}}};
	assign prev_idx = (idx_q == '0) ? '0 : idx_q - 1'b1;

	// point registers and products
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			x_q       <= pt.point_x_mm;
			y_q       <= pt.point_y_mm;
			fin_q     <= pt.final_point | (cnt_q >= IdxLast);
			idx_q     <= cnt_q;
			self_q    <= !started_q;
			process_q <= (cnt_q != '0) | cfg.double_first_point;
		end
		if (cmd.sq_mul) begin
			xx_q  <= xx_full[46:0];
			yy_q  <= yy_full[46:0];
			dxx_q <= dxx_full[48:0];
			dyy_q <= dyy_full[48:0];
		end
		if (cmd.root_start) begin
			r2_q <= r2_sum;
		end
		if (cmd.gap_mul) begin
			prod_q <= 45'(rq) * 45'(cfg.gap_proportion_q16);
			b_q    <= self_q ? rq : prev_rq_q;
			p2_q   <= self_q ? r2_q : prev_r2_q;
		end
		if (cmd.h_load) begin
			f2m_q    <= f2[30] ? 30'(-f2) : f2[29:0];
			f3m_q    <= f3[30] ? 30'(-f3) : f3[29:0];
			f4m_q    <= f4[30] ? 30'(-f4) : f4[29:0];
			undef_q  <= (rq == '0) || (b_q == '0)
				|| ((f2[30] ^ f3[30] ^ f4[30]) && (f2 != 0) && (f3 != 0) && (f4 != 0));
			nearer_q <= r2_q < p2_q;
			big_q    <= BigW'(abc);
			carry_q  <= '0;
		end else if (cmd.mul_en) begin
			big_q   <= {mac[LimbW-1:0], big_q[BigW-1:LimbW]};
			carry_q <= cmd.mul_last ? '0 : mac[2*LimbW-1:LimbW];
		end else if (cmd.swap) begin
			lhs_q <= big_q[LhsW-1:0];
			big_q <= BigW'({rq, 2'b00});
		end
		if (cmd.cmp) begin
			occl_q <= !undef_q && (lhs_wide < big_q);
			gt_q   <= !undef_q && (lhs_wide > big_q);
		end
	end

	// open group and sweep state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			started_q    <= 1'b0;
			cnt_q        <= '0;
			open_first_q <= '0;
			count_q      <= '0;
			fv_q         <= 1'b1;
			prev_x_q     <= '0;
			prev_y_q     <= '0;
			prev_r2_q    <= '0;
			prev_rq_q    <= '0;
		end else begin
			if (cmd.load && !started_q) begin
				started_q    <= 1'b1;
				open_first_q <= '0;
				count_q      <= CntW'(1);
				fv_q         <= 1'b1;
				prev_x_q     <= pt.point_x_mm;
				prev_y_q     <= pt.point_y_mm;
			end
			if (cmd.join_grp && count_q != spbg_pkg::CNT_MAX) begin
				count_q <= count_q + 1'b1;
			end
			if (cmd.emit_brk) begin
				open_first_q <= idx_q;
				count_q      <= CntW'(1);
				fv_q         <= gt_q | nearer_q;
			end
			if (cmd.post) begin
				prev_x_q  <= x_q;
				prev_y_q  <= y_q;
				prev_r2_q <= r2_q;
				prev_rq_q <= rq;
				cnt_q     <= idx_q + 1'b1;
			end
			if (cmd.emit_fin) begin
				started_q <= 1'b0;
				cnt_q     <= '0;
			end
		end
	end

	// result register: hold until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit_brk || cmd.emit_fin) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit_brk) begin
			out_q.group_first     <= IdxW'(open_first_q);
			out_q.group_last      <= IdxW'(prev_idx);
			out_q.point_count     <= count_q;
			out_q.front_seen      <= fv_q;
			out_q.back_seen       <= !(occl_q && nearer_q);
			out_q.occlusion_break <= occl_q;
			out_q.too_small       <= count_q < cfg.min_group_size;
			out_q.last_of_sweep   <= 1'b0;
		end else if (cmd.emit_fin) begin
			out_q.group_first     <= IdxW'(open_first_q);
			out_q.group_last      <= IdxW'(idx_q);
			out_q.point_count     <= count_q;
			out_q.front_seen      <= fv_q;
			out_q.back_seen       <= 1'b1;
			out_q.occlusion_break <= 1'b0;
			out_q.too_small       <= count_q < cfg.min_group_size;
			out_q.last_of_sweep   <= 1'b1;
		end
	end

	assign out_valid      = out_valid_q;
	assign out_grp        = out_q;
	assign sts.process    = process_q;
	assign sts.join_ok    = {1'b0, dq} < thr;
	assign sts.fin        = fin_q;
	assign sts.roots_done = r_done & d_done;
	assign sts.out_free   = !out_valid_q || out_ready;
endmodule

// File: hw/rtl/spbg_ctrl.sv
// ----------------------------------------------------------------------------
// spbg_ctrl
// Sequencer for one scan point: squares, roots, gap decision, Heron
// multiply steps and result hand-off.
// ----------------------------------------------------------------------------
module spbg_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  spbg_pkg::sts_t   sts,
	output spbg_pkg::cmd_t   cmd
);
	localparam logic [3:0] S_IDLE   = 4'd0;
	localparam logic [3:0] S_SQR    = 4'd1;
	localparam logic [3:0] S_SUM    = 4'd2;
	localparam logic [3:0] S_ROOT   = 4'd3;
	localparam logic [3:0] S_GAP    = 4'd4;
	localparam logic [3:0] S_DECIDE = 4'd5;
	localparam logic [3:0] S_HLOAD  = 4'd6;
	localparam logic [3:0] S_MUL    = 4'd7;
	localparam logic [3:0] S_SWAP   = 4'd8;
	localparam logic [3:0] S_CMP    = 4'd9;
	localparam logic [3:0] S_EMITB  = 4'd10;
	localparam logic [3:0] S_POST   = 4'd11;
	localparam logic [3:0] S_EMITF  = 4'd12;

	localparam logic [2:0] LimbLast = 3'(spbg_pkg::LIMBS - 1);

	logic [3:0] state_q, state_d;
	logic [2:0] step_q, step_d;
	logic [2:0] limb_q, limb_d;

	// next state and commands
	always_comb begin
		state_d = state_q;
		step_d  = step_q;
		limb_d  = limb_q;
		cmd     = '0;
		cmd.mul_step = step_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_SQR;
				end
			end
			S_SQR: begin
				cmd.sq_mul = 1'b1;
				state_d    = S_SUM;
			end
			S_SUM: begin
				cmd.root_start = 1'b1;
				state_d        = S_ROOT;
			end
			S_ROOT: begin
				if (sts.roots_done) begin
					state_d = S_GAP;
				end
			end
			S_GAP: begin
				cmd.gap_mul = 1'b1;
				state_d     = S_DECIDE;
			end
			S_DECIDE: begin
				if (!sts.process) begin
					state_d = S_POST;
				end else if (sts.join_ok) begin
					cmd.join_grp = 1'b1;
					state_d      = S_POST;
				end else begin
					state_d = S_HLOAD;
				end
			end
			S_HLOAD: begin
				cmd.h_load = 1'b1;
				step_d     = spbg_pkg::MS_F2;
				limb_d     = '0;
				state_d    = S_MUL;
			end
			S_MUL: begin
				cmd.mul_en   = 1'b1;
				cmd.mul_last = limb_q == LimbLast;
				if (limb_q == LimbLast) begin
					limb_d = '0;
					if (step_q == spbg_pkg::MS_F4) begin
						step_d  = spbg_pkg::MS_A;
						state_d = S_SWAP;
					end else if (step_q == spbg_pkg::MS_T2) begin
						state_d = S_CMP;
					end else begin
						step_d = step_q + 1'b1;
					end
				end else begin
					limb_d = limb_q + 1'b1;
				end
			end
			S_SWAP: begin
				cmd.swap = 1'b1;
				state_d  = S_MUL;
			end
			S_CMP: begin
				cmd.cmp = 1'b1;
				state_d = S_EMITB;
			end
			S_EMITB: begin
				if (sts.out_free) begin
					cmd.emit_brk = 1'b1;
					state_d      = S_POST;
				end
			end
			S_POST: begin
				cmd.post = 1'b1;
				state_d  = sts.fin ? S_EMITF : S_IDLE;
			end
			S_EMITF: begin
				if (sts.out_free) begin
					cmd.emit_fin = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			step_q  <= '0;
			limb_q  <= '0;
		end else begin
			state_q <= state_d;
			step_q  <= step_d;
			limb_q  <= limb_d;
		end
	end

	assign in_ready = state_q == S_IDLE;

	a_limb_range: assert property (@(posedge clk) disable iff (!arst_n)
		limb_q <= LimbLast)
		else $error("limb counter out of range");

	a_mul_end: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_MUL && step_q == spbg_pkg::MS_T2 && limb_q == LimbLast)
		|=> state_q == S_CMP)
		else $error("multiply sequence did not end in compare");

	a_emit_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EMITB && !sts.out_free) |=> state_q == S_EMITB)
		else $error("break word dropped while result register full");

	a_swap_once: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SWAP) |-> (step_q == spbg_pkg::MS_A && limb_q == '0))
		else $error("operand swap out of sequence");
endmodule

// File: hw/rtl/scan_point_breakpoint_grouper_core.sv
// ----------------------------------------------------------------------------
// scan_point_breakpoint_grouper_core
// Adaptive breakpoint grouping of laser scan points with an occlusion test.
//
//   channel  dir  handshake       word
//   points   in   valid/ready     point_x_mm, point_y_mm, final_point
//   groups   out  valid/ready     one closed group per word
//   apb      in   psel/penable    five configuration registers at 4*i
//
// The time a point takes to join or open the sweep is set by the two
// one-bit-per-cycle root units, run side by side. A break adds eight
// 160-bit by 32-bit multiply steps, five limbs each, on one 32x32
// multiplier. A final point adds an emit step for its word. One point is
// worked on at a time; the next point is taken while the last word waits in
// the result register, and a full result register stalls only the emitting
// step. Reset is asynchronous.
// ----------------------------------------------------------------------------
module scan_point_breakpoint_grouper_core #(
	parameter int MAX_POINTS = 1024
) (
	input  logic                            clk,
	input  logic                            arst_n,
	spbg_stream_if.sink                     points,
	spbg_stream_if.source                   groups,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [spbg_pkg::APB_AW-1:0]     paddr,
	input  logic [31:0]                     pwdata,
	output logic [31:0]                     prdata,
	output logic                            pready
);
	spbg_pkg::cfg_t cfg_q;
	spbg_pkg::cmd_t cmd;
	spbg_pkg::sts_t sts;
	logic [2:0]     reg_idx;
	logic           wr_en;
	logic           in_ready;

	assign reg_idx = paddr[spbg_pkg::APB_AW-1:2];
	assign wr_en   = psel && penable && pwrite;
	assign pready  = 1'b1;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.base_gap_mm        <= 16'd100;
			cfg_q.gap_proportion_q16 <= 16'd4571;
			cfg_q.sine_threshold_q16 <= 17'd9093;
			cfg_q.min_group_size     <= 11'd5;
			cfg_q.double_first_point <= 1'b0;
		end else if (wr_en) begin
			unique case (reg_idx)
				spbg_pkg::REG_BASE_GAP:     cfg_q.base_gap_mm        <= pwdata[15:0];
				spbg_pkg::REG_GAP_PROP:     cfg_q.gap_proportion_q16 <= pwdata[15:0];
				spbg_pkg::REG_SINE_THR:     cfg_q.sine_threshold_q16 <= pwdata[16:0];
				spbg_pkg::REG_MIN_SIZE:     cfg_q.min_group_size     <= pwdata[10:0];
				spbg_pkg::REG_DOUBLE_FIRST: cfg_q.double_first_point <= pwdata[0];
				default: begin
				end
			endcase
		end
	end

	// register read-back
	always_comb begin
		unique case (reg_idx)
			spbg_pkg::REG_BASE_GAP:     prdata = 32'(cfg_q.base_gap_mm);
			spbg_pkg::REG_GAP_PROP:     prdata = 32'(cfg_q.gap_proportion_q16);
			spbg_pkg::REG_SINE_THR:     prdata = 32'(cfg_q.sine_threshold_q16);
			spbg_pkg::REG_MIN_SIZE:     prdata = 32'(cfg_q.min_group_size);
			spbg_pkg::REG_DOUBLE_FIRST: prdata = 32'(cfg_q.double_first_point);
			default:                    prdata = '0;
		endcase
	end

	spbg_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (points.valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	spbg_dpath #(
		.MAX_POINTS (MAX_POINTS)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.cmd       (cmd),
		.sts       (sts),
		.pt        (points.data),
		.out_ready (groups.ready),
		.out_valid (groups.valid),
		.out_grp   (groups.data)
	);

	assign points.ready = in_ready;
endmodule
